// File: design/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, codes and defaults for the double-ended queue core.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int WORD_W        = 32;
   localparam int KIND_W        = 3;
   localparam int STATUS_W      = 2;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_PEEK_FRONT = 3'd4;
   localparam logic [KIND_W-1:0] KIND_PEEK_REAR  = 3'd5;

   // result status
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch the accepted request
      logic execute;   // update indexes, write or read the ring
      logic load;      // move the result into the output register
   } deq_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;  // output register empty or being taken this cycle
   } deq_stat_type;

endpackage

// File: design/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Request sequencer: accept, execute, then hand the result to the output.
// ----------------------------------------------------------------------------
module deq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  deq_pkg::deq_stat_type stat,
   output deq_pkg::deq_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      cmd.load    = 1'b0;
      req_stall   = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = ST_LOAD;
         end
         ST_LOAD: begin
            // wait here while a previous result is still held
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/deq_dpath.sv
// ----------------------------------------------------------------------------
// deq_dpath
// Ring indexes, occupancy, slot RAM and output register of the queue.
// ----------------------------------------------------------------------------
module deq_dpath #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  deq_pkg::deq_cmd_type                cmd,
   output deq_pkg::deq_stat_type               stat,
   input  logic [deq_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [deq_pkg::WORD_W-1:0]   req_push_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [deq_pkg::WORD_W-1:0]   rsp_read_value,
   output logic [deq_pkg::STATUS_W-1:0]        rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]          rsp_occupancy
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = AW + 2;

   // latched request
   logic [deq_pkg::KIND_W-1:0] kind_ff;
   logic [deq_pkg::WORD_W-1:0] value_ff;

   // queue state
   logic [AW-1:0] head_ff;
   logic [AW-1:0] head_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   // pending result between execute and load
   logic [deq_pkg::STATUS_W-1:0] pend_status_ff;
   logic [deq_pkg::STATUS_W-1:0] pend_status_in;
   logic                         pend_read_ff;
   logic                         pend_read_in;

   // output register
   logic                         out_valid_ff;
   logic [deq_pkg::WORD_W-1:0]   out_value_ff;
   logic [deq_pkg::STATUS_W-1:0] out_status_ff;
   logic [CW-1:0]                out_occ_ff;

   logic          is_push;
   logic          is_read;
   logic          is_front_read;
   logic          full;
   logic          empty;
   logic          push_ok;
   logic          read_ok;
   logic [AW-1:0] head_dec;
   logic [AW-1:0] head_inc;
   logic [SW-1:0] tail_sum;
   logic [SW-1:0] rear_sum;
   logic [AW-1:0] tail_slot;
   logic [AW-1:0] rear_slot;
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [deq_pkg::WORD_W-1:0] ram_rd_data;

   assign is_push = (kind_ff == deq_pkg::KIND_PUSH_FRONT) ||
                    (kind_ff == deq_pkg::KIND_PUSH_REAR);
   assign is_read = (kind_ff == deq_pkg::KIND_POP_FRONT)  ||
                    (kind_ff == deq_pkg::KIND_POP_REAR)   ||
                    (kind_ff == deq_pkg::KIND_PEEK_FRONT) ||
                    (kind_ff == deq_pkg::KIND_PEEK_REAR);
   assign is_front_read = (kind_ff == deq_pkg::KIND_POP_FRONT) ||
                          (kind_ff == deq_pkg::KIND_PEEK_FRONT);

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = is_push && !full;
   assign read_ok = is_read && !empty;

   // ring index arithmetic; sums stay below twice the depth whenever the queue holds a word
   assign head_dec = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign head_inc = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
   assign tail_sum = SW'(head_ff) + SW'(count_ff);
   assign rear_sum = tail_sum - SW'(1);
   assign tail_slot = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
   assign rear_slot = (rear_sum >= SW'(DEPTH)) ? AW'(rear_sum - SW'(DEPTH)) : AW'(rear_sum);

   assign ram_wr_en   = cmd.execute && push_ok;
   assign ram_wr_addr = (kind_ff == deq_pkg::KIND_PUSH_FRONT) ? head_dec : tail_slot;
   assign ram_rd_en   = cmd.execute && read_ok;
   assign ram_rd_addr = is_front_read ? head_ff : rear_slot;

   always_comb begin
      head_in        = head_ff;
      count_in       = count_ff;
      pend_status_in = pend_status_ff;
      pend_read_in   = pend_read_ff;
      if (cmd.execute) begin
         pend_status_in = deq_pkg::STATUS_OK;
         pend_read_in   = read_ok;
         if (is_push && full) begin
            pend_status_in = deq_pkg::STATUS_FULL;
         end else if (is_read && empty) begin
            pend_status_in = deq_pkg::STATUS_EMPTY;
         end
         if (push_ok) begin
            count_in = count_ff + CW'(1);
            if (kind_ff == deq_pkg::KIND_PUSH_FRONT) begin
               head_in = head_dec;
            end
         end
         if (read_ok && (kind_ff == deq_pkg::KIND_POP_FRONT)) begin
            head_in  = head_inc;
            count_in = count_ff - CW'(1);
         end
         if (read_ok && (kind_ff == deq_pkg::KIND_POP_REAR)) begin
            count_in = count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         if (cmd.load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_read_ff   <= pend_read_in;
      if (cmd.capture) begin
         kind_ff  <= req_kind;
         value_ff <= req_push_value;
      end
      if (cmd.load) begin
         out_value_ff  <= pend_read_ff ? ram_rd_data : '0;
         out_status_ff <= pend_status_ff;
         out_occ_ff    <= count_ff;
      end
   end

   deq_ram #(
      .WIDTH (deq_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (value_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign stat.out_free  = !out_valid_ff || !rsp_stall;
   assign rsp_valid      = out_valid_ff;
   assign rsp_read_value = out_value_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_occupancy  = out_occ_ff;

endmodule

// File: design/double_ended_queue_core.sv
// Sequence: a request word is captured, then executed against the ring and the
// slot RAM, then its result is loaded into the output register once that is free.
// A new request is taken only after the previous result has been loaded, set by
// the accept/execute/load sequence around the slot RAM's registered read port.
// The output register holds one result, so the next request is accepted while
// the previous result still waits on rsp_stall.
// Reset: synchronous, active high; empties the queue (head and count to zero).
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue of signed 32-bit words kept in a ring of slots.
// ----------------------------------------------------------------------------
module double_ended_queue_core #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [deq_pkg::KIND_W-1:0]         req_kind,
   input  logic signed [deq_pkg::WORD_W-1:0]  req_push_value,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [deq_pkg::WORD_W-1:0]  rsp_read_value,
   output logic [deq_pkg::STATUS_W-1:0]       rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_occupancy
);

   // Control/data split: the controller sequences each request word through
   // capture -> execute -> load; the datapath owns the head index, the
   // occupancy count, the slot RAM and the output register.
   deq_pkg::deq_cmd_type  cmd;
   deq_pkg::deq_stat_type stat;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Pushes write one slot during execute; pops and peeks read one slot
   // during execute and take the registered data at load. An empty pop/peek
   // or a push to a full queue touches nothing and only reports status.
   deq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_kind       (req_kind),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy)
   );

endmodule

// File: tb/double_ended_queue_core_test.sv
// ----------------------------------------------------------------------------
// double_ended_queue_core_test
// Drives push, pop and peek requests into the queue core and checks every
// response word against a cycle-free mirror of the ring, with random idling
// on both channels.
// ----------------------------------------------------------------------------
module double_ended_queue_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = deq_pkg::DEPTH_DEFAULT;
   localparam int OCC_W = $clog2(DEPTH + 1);

   // kind codes the core has no use for; it must answer ok, occupancy unchanged
   localparam logic [deq_pkg::KIND_W-1:0] KIND_SPARE_6 = 3'd6;
   localparam logic [deq_pkg::KIND_W-1:0] KIND_SPARE_7 = 3'd7;

   localparam int IDLE_PCT       = 28;    // idle chance per cycle, both sides
   localparam int MAX_GAP        = 8;     // cap on one sender gap
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving at all
   localparam int DRAIN_CYCLES   = 12;    // margin after the last response
   localparam int BLOCKS         = 32;
   localparam int BLOCK_LEN      = 60;

   // direction a block of random traffic leans toward
   typedef enum {BIAS_FILL, BIAS_DRAIN, BIAS_MIXED} bias_type;

   // -------------------------------------------------------------------------
   // Mirror of the ring: head slot, occupancy and slot contents, plus the
   // response words still owed by the core, oldest first.
   // -------------------------------------------------------------------------
   class ring_mirror;
      typedef struct {
         logic signed [deq_pkg::WORD_W-1:0] read_value;
         logic [deq_pkg::STATUS_W-1:0]      status;
         logic [OCC_W-1:0]                  occupancy;
      } reply_type;

      logic [deq_pkg::WORD_W-1:0] ring[DEPTH];
      int unsigned                front;
      int unsigned                held;
      reply_type                  owed[$];
      int unsigned                failures;

      function new();
         front    = 0;
         held     = 0;
         failures = 0;
         foreach (ring[i]) ring[i] = '0;
      endfunction

      function int pending();
         return owed.size();
      endfunction

      // accepted request word: update the ring and queue up the reply
      function void note_request(logic [deq_pkg::KIND_W-1:0] kind,
                                 logic signed [deq_pkg::WORD_W-1:0] word);
         reply_type   r;
         int unsigned slot;
         r.read_value = '0;
         r.status     = deq_pkg::STATUS_OK;
         case (kind)
            deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_REAR: begin
               if (held >= DEPTH) begin
                  r.status = deq_pkg::STATUS_FULL;
               end else if (kind == deq_pkg::KIND_PUSH_FRONT) begin
                  front       = (front + DEPTH - 1) % DEPTH;
                  ring[front] = word;
                  held++;
               end else begin
                  ring[(front + held) % DEPTH] = word;
                  held++;
               end
            end
            deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_REAR,
            deq_pkg::KIND_PEEK_FRONT, deq_pkg::KIND_PEEK_REAR: begin
               if (held == 0) begin
                  r.status = deq_pkg::STATUS_EMPTY;
               end else begin
                  slot = (kind == deq_pkg::KIND_POP_FRONT ||
                          kind == deq_pkg::KIND_PEEK_FRONT) ?
                         front : (front + held - 1) % DEPTH;
                  r.read_value = ring[slot];
                  if (kind == deq_pkg::KIND_POP_FRONT) begin
                     front = (front + 1) % DEPTH;
                     held--;
                  end else if (kind == deq_pkg::KIND_POP_REAR) begin
                     held--;
                  end
               end
            end
            default: ;
         endcase
         r.occupancy = held[OCC_W-1:0];
         owed.push_back(r);
      endfunction

      function void check_response(logic signed [deq_pkg::WORD_W-1:0] read_value,
                                   logic [deq_pkg::STATUS_W-1:0] status,
                                   logic [OCC_W-1:0] occupancy);
         reply_type r;
         if (owed.size() == 0) begin
            $error("response word with none outstanding: read_value %0d status %0d",
                   read_value, status);
            failures++;
            return;
         end
         r = owed[0];
         owed.delete(0);
         if (read_value !== r.read_value) begin
            $error("read_value: expected %0d, got %0d", r.read_value, read_value);
            failures++;
         end
         if (status !== r.status) begin
            $error("status: expected %0d, got %0d", r.status, status);
            failures++;
         end
         if (occupancy !== r.occupancy) begin
            $error("occupancy: expected %0d, got %0d", r.occupancy, occupancy);
            failures++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and DUT
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid      = 1'b0;
   logic                              req_stall;
   logic [deq_pkg::KIND_W-1:0]        req_kind       = deq_pkg::KIND_PEEK_FRONT;
   logic signed [deq_pkg::WORD_W-1:0] req_push_value = '0;
   logic                              rsp_valid;
   logic                              rsp_stall      = 1'b0;
   logic signed [deq_pkg::WORD_W-1:0] rsp_read_value;
   logic [deq_pkg::STATUS_W-1:0]      rsp_status;
   logic [OCC_W-1:0]                  rsp_occupancy;

   // steady = no idling on either side
   bit steady = 1'b0;

   ring_mirror mirror = new();

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   double_ended_queue_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy)
   );

   // -------------------------------------------------------------------------
   // Response side: random backpressure, check each word taken.
   // Values are sampled at the edge, before any nonblocking update lands.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         mirror.check_response(rsp_read_value, rsp_status, rsp_occupancy);
   end

   // -------------------------------------------------------------------------
   // Watchdog: any run of cycles with no word moving on either channel
   // longer than the limit means the core hung.
   // -------------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("[double_ended_queue_core] ERROR");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Offer one request word and hold it until taken. An optional random gap
   // goes first; valid is only ever written once per edge.
   task automatic send_word(input logic [deq_pkg::KIND_W-1:0] kind,
                            input logic signed [deq_pkg::WORD_W-1:0] value);
      int gap;
      gap = 0;
      if (!steady)
         while (gap < MAX_GAP && $urandom_range(0, 99) < IDLE_PCT) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_push_value <= value;
      do @(posedge clock); while (req_stall);
      mirror.note_request(kind, value);
   endtask

   // Sender holds off until every owed response word has come back.
   task automatic wait_all_answered();
      req_valid <= 1'b0;
      do @(posedge clock); while (mirror.pending() != 0);
   endtask

   // Mostly full-range random, now and then a corner value.
   function automatic logic signed [deq_pkg::WORD_W-1:0] pick_word();
      case ($urandom_range(0, 15))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // Weighted kind choice; fill blocks reach full, drain blocks hit empty.
   function automatic logic [deq_pkg::KIND_W-1:0] pick_kind(bias_type bias);
      int push_pct;
      int pop_pct;
      int roll;
      case (bias)
         BIAS_FILL:  begin push_pct = 65; pop_pct = 20; end
         BIAS_DRAIN: begin push_pct = 20; pop_pct = 65; end
         default:    begin push_pct = 42; pop_pct = 42; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < push_pct)
         return $urandom_range(0, 1) ? deq_pkg::KIND_PUSH_REAR : deq_pkg::KIND_PUSH_FRONT;
      if (roll < push_pct + pop_pct)
         return $urandom_range(0, 1) ? deq_pkg::KIND_POP_REAR : deq_pkg::KIND_POP_FRONT;
      if (roll < 96)
         return $urandom_range(0, 1) ? deq_pkg::KIND_PEEK_REAR : deq_pkg::KIND_PEEK_FRONT;
      return $urandom_range(0, 1) ? KIND_SPARE_7 : KIND_SPARE_6;
   endfunction

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      logic signed [deq_pkg::WORD_W-1:0] corners[9];
      bias_type bias;
      corners = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, -32'sd1, 32'sd1,
                  32'sh8000_0001, 32'sh7fff_fffe, 32'sh5555_5555, 32'shaaaa_aaaa};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every read kind on an empty queue
      send_word(deq_pkg::KIND_POP_FRONT, $urandom);
      send_word(deq_pkg::KIND_POP_REAR, $urandom);
      send_word(deq_pkg::KIND_PEEK_FRONT, $urandom);
      send_word(deq_pkg::KIND_PEEK_REAR, $urandom);

      // fill to the brim from both ends, extreme words first (wraps the head)
      for (int i = 0; i < DEPTH; i++)
         send_word((i % 2) ? deq_pkg::KIND_PUSH_REAR : deq_pkg::KIND_PUSH_FRONT,
                   (i < 9) ? corners[i] : pick_word());

      // pushes on a full queue get dropped
      send_word(deq_pkg::KIND_PUSH_FRONT, 32'sh7fff_ffff);
      send_word(deq_pkg::KIND_PUSH_REAR, 32'sh8000_0000);
      send_word(deq_pkg::KIND_PEEK_FRONT, $urandom);
      send_word(deq_pkg::KIND_PEEK_REAR, $urandom);
      send_word(KIND_SPARE_7, $urandom);

      // random blocks, each leaning to fill, drain or neither
      for (int b = 0; b < BLOCKS; b++) begin
         // long stretch with no idling on either channel
         steady = (b >= 4 && b < 8);
         case (b % 4)
            0:       bias = BIAS_DRAIN;
            1:       bias = BIAS_FILL;
            2:       bias = BIAS_DRAIN;
            default: bias = BIAS_MIXED;
         endcase
         for (int i = 0; i < BLOCK_LEN; i++)
            send_word(pick_kind(bias), pick_word());
         // sender goes quiet until the core has answered everything
         if (b == 12 || b == 21)
            wait_all_answered();
      end

      req_valid <= 1'b0;
      steady = 1'b0;
      do @(posedge clock); while (mirror.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mirror.failures == 0 && mirror.pending() == 0)
         $display("[double_ended_queue_core] OK");
      else
         $display("[double_ended_queue_core] ERROR");
      $finish;
   end

endmodule
